/* src/lttl_pkg.sv */
// ----------------------------------------------------------------------------
// lttl_pkg
// Shared codes and types of the lru/ttl cache directory: operation kinds,
// event codes, configuration register indexes and the compare unit result.
// ----------------------------------------------------------------------------
package lttl_pkg;

    // operation kinds
    localparam logic [2:0] KIND_ACQUIRE  = 3'd0;
    localparam logic [2:0] KIND_SET_DIRTY = 3'd1;
    localparam logic [2:0] KIND_DROP     = 3'd2;
    localparam logic [2:0] KIND_DROP_ALL = 3'd3;
    localparam logic [2:0] KIND_FLUSH    = 3'd4;
    localparam logic [2:0] KIND_SWEEP    = 3'd5;

    // result events
    localparam logic [2:0] EV_HIT     = 3'd0;
    localparam logic [2:0] EV_LOADED  = 3'd1;
    localparam logic [2:0] EV_REMOVED = 3'd2;
    localparam logic [2:0] EV_KEPT    = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;

    // configuration registers
    localparam int         CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIFE     = 1'd1;
    localparam logic [4:0]  CAP_RESET  = 5'd16;
    localparam logic [31:0] LIFE_RESET = 32'd60000;

    // compare unit result
    typedef struct packed {
        logic        key_eq;
        logic        over;
        logic [31:0] age;
    } t_cmp_res;

endpackage

/* src/lttl_ram.sv */
// ----------------------------------------------------------------------------
// lttl_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module lttl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lttl_cmp.sv */
// ----------------------------------------------------------------------------
// lttl_cmp
// Shared compare unit: key equality, wrapping age of an entry and a strict
// compare of that age against a selected limit (best age or lifetime).
// ----------------------------------------------------------------------------
module lttl_cmp #(
    parameter int KEY_W = 32
) (
    input  logic [KEY_W-1:0]   i_key_a,
    input  logic [KEY_W-1:0]   i_key_b,
    input  logic [31:0]        i_now,
    input  logic [31:0]        i_last_use,
    input  logic [31:0]        i_limit,
    output lttl_pkg::t_cmp_res o_res
);

    import lttl_pkg::*;

    logic [31:0] w_age;

    // wrapping subtraction
    assign w_age = i_now - i_last_use;

    always_comb begin
        o_res.key_eq = (i_key_a == i_key_b);
        o_res.age    = w_age;
        o_res.over   = (w_age > i_limit);
    end

endmodule

/* src/lru_ttl_cache_directory_top.sv */
// ----------------------------------------------------------------------------
// lru_ttl_cache_directory_top
// Directory of a small fully associative cache with lru replacement and
// idle-time expiry, run by a sequencer over one entry ram and compare unit.
// ----------------------------------------------------------------------------
// The list of entries lives in a ram with one read and one write port and is
// walked one entry at a time: each visited entry is read, then evaluated in
// the shared compare unit, and closing a gap after a removal moves each
// later entry up one place (check, then write). An acquire hit reads the
// list up to the entry found; a miss scans the whole list, may evict and
// close the gap, then appends. Drop all, flush all and sweep visit every
// entry and issue one result transfer per affected entry plus a final done.
// The input is stalled for the whole of an item's work. A result held by a
// stalled consumer holds up the sequencer only when it has the next result
// to issue. Configuration writes are always taken; write them only while the
// block is idle.
// ----------------------------------------------------------------------------
module lru_ttl_cache_directory_top #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_kind,
    input  logic [31:0]                        i_key,
    input  logic [31:0]                        i_now_ms,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_event_res,
    output logic [31:0]                        o_entry_key,
    output logic                               o_wrote_back,
    output logic                               o_found,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lttl_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    import lttl_pkg::*;

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic          dirty;
        logic [31:0]   last_use;
        logic [KW-1:0] key;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_HIT,
        S_MISS,
        S_APPEND,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic [2:0]    r_kind;
    logic [KW-1:0] r_key;
    logic [31:0]   r_now;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_victim;
    logic [31:0]   r_best;
    logic [KW-1:0] r_vkey;
    logic          r_vdirty;
    logic [4:0]    r_cap;
    logic [31:0]   r_life;

    logic          r_out_valid;
    logic [2:0]    r_event_res;
    logic [31:0]   r_entry_key;
    logic          r_wrote_back;
    logic          r_found;
    logic          r_last;

    t_entry        w_rd;
    logic [EW-1:0] w_rdata;
    t_entry        w_wdata;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    t_cmp_res      w_cmp;
    logic [31:0]   w_limit;
    logic [CW-1:0] w_cap_eff;
    logic          w_full;
    logic [CW-1:0] w_pos_inc;
    logic          w_more;
    logic          w_out_free;
    logic          w_want;
    logic          w_ok;
    logic [2:0]    w_ev_res;
    logic [KW-1:0] w_ev_key;
    logic          w_ev_wb;
    logic          w_ev_found;
    logic          w_ev_last;

    assign w_rd = t_entry'(w_rdata);

    lttl_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_limit = (r_kind == KIND_SWEEP) ? r_life : r_best;

    lttl_cmp #(
        .KEY_W (KW)
    ) u_cmp (
        .i_key_a    (w_rd.key),
        .i_key_b    (r_key),
        .i_now      (r_now),
        .i_last_use (w_rd.last_use),
        .i_limit    (w_limit),
        .o_res      (w_cmp)
    );

    // capacity register clamped to 1..CAPACITY
    always_comb begin
        if (r_cap == 5'd0) begin
            w_cap_eff = CW'(1);
        end else if (32'(r_cap) > CAPACITY) begin
            w_cap_eff = CW'(CAPACITY);
        end else begin
            w_cap_eff = CW'(r_cap);
        end
    end

    assign w_full     = (r_count >= w_cap_eff);
    assign w_pos_inc  = r_pos + CW'(1);
    assign w_more     = (w_pos_inc < r_count);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ok       = !w_want || w_out_free;
    assign w_raddr    = (r_state == S_SHIFT_CHK) ? w_pos_inc[IW-1:0] : r_pos[IW-1:0];

    // result to emit and ram write for the current step
    always_comb begin
        w_want     = 1'b0;
        w_ev_res   = EV_DONE;
        w_ev_key   = '0;
        w_ev_wb    = 1'b0;
        w_ev_found = 1'b0;
        w_ev_last  = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_pos[IW-1:0];
        w_wdata    = w_rd;
        case (r_state)
            S_EVAL: begin
                case (r_kind)
                    KIND_DROP_ALL: begin
                        w_want   = 1'b1;
                        w_ev_res = EV_REMOVED;
                        w_ev_key = w_rd.key;
                        w_ev_wb  = w_rd.dirty;
                    end
                    KIND_FLUSH: begin
                        if (w_rd.dirty) begin
                            w_want        = 1'b1;
                            w_ev_res      = EV_KEPT;
                            w_ev_key      = w_rd.key;
                            w_ev_wb       = 1'b1;
                            w_we          = w_out_free;
                            w_wdata.dirty = 1'b0;
                        end
                    end
                    KIND_SWEEP: begin
                        if (w_cmp.over) begin
                            w_want   = 1'b1;
                            w_ev_res = EV_REMOVED;
                            w_ev_key = w_rd.key;
                            w_ev_wb  = w_rd.dirty;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_HIT: begin
                w_want     = 1'b1;
                w_ev_key   = r_key;
                w_ev_found = 1'b1;
                w_ev_last  = 1'b1;
                case (r_kind)
                    KIND_ACQUIRE: begin
                        w_ev_res         = EV_HIT;
                        w_we             = w_out_free;
                        w_wdata.last_use = r_now;
                    end
                    KIND_SET_DIRTY: begin
                        w_ev_res      = EV_DONE;
                        w_we          = w_out_free;
                        w_wdata.dirty = 1'b1;
                    end
                    default: begin
                        w_ev_res = EV_REMOVED;
                        w_ev_wb  = w_rd.dirty;
                    end
                endcase
            end
            S_MISS: begin
                if (r_kind == KIND_ACQUIRE) begin
                    if (w_full) begin
                        w_want   = 1'b1;
                        w_ev_res = EV_REMOVED;
                        w_ev_key = r_vkey;
                        w_ev_wb  = r_vdirty;
                    end
                end else begin
                    w_want    = 1'b1;
                    w_ev_res  = EV_DONE;
                    w_ev_key  = r_key;
                    w_ev_last = 1'b1;
                end
            end
            S_APPEND: begin
                w_want           = 1'b1;
                w_ev_res         = EV_LOADED;
                w_ev_key         = r_key;
                w_ev_last        = 1'b1;
                w_we             = w_out_free;
                w_waddr          = r_count[IW-1:0];
                w_wdata.dirty    = 1'b0;
                w_wdata.last_use = r_now;
                w_wdata.key      = r_key;
            end
            S_SHIFT_WR: begin
                w_we = 1'b1;
            end
            S_FINISH: begin
                w_want    = 1'b1;
                w_ev_res  = EV_DONE;
                w_ev_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
            r_life      <= LIFE_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap  <= i_cfg_data[4:0];
                    CFG_LIFE:     r_life <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_want && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_event_res  <= w_ev_res;
                r_entry_key  <= 32'(w_ev_key);
                r_wrote_back <= w_ev_wb;
                r_found      <= w_ev_found;
                r_last       <= w_ev_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind <= i_kind;
                        r_key  <= i_key[KW-1:0];
                        r_now  <= i_now_ms;
                        r_pos  <= '0;
                        r_best <= '0;
                        case (i_kind)
                            KIND_ACQUIRE, KIND_SET_DIRTY, KIND_DROP: begin
                                r_state <= (r_count == '0) ? S_MISS : S_READ;
                            end
                            KIND_DROP_ALL, KIND_FLUSH, KIND_SWEEP: begin
                                r_state <= (r_count == '0) ? S_FINISH : S_READ;
                            end
                            default: r_state <= S_FINISH;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    case (r_kind)
                        KIND_ACQUIRE, KIND_SET_DIRTY, KIND_DROP: begin
                            if (w_cmp.key_eq) begin
                                r_state <= S_HIT;
                            end else begin
                                // oldest so far, earliest listed wins ties
                                if (r_kind == KIND_ACQUIRE &&
                                    (r_pos == '0 || w_cmp.over)) begin
                                    r_best   <= w_cmp.age;
                                    r_victim <= r_pos;
                                    r_vkey   <= w_rd.key;
                                    r_vdirty <= w_rd.dirty;
                                end
                                if (w_more) begin
                                    r_pos   <= w_pos_inc;
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_MISS;
                                end
                            end
                        end
                        KIND_SWEEP: begin
                            if (w_cmp.over) begin
                                if (w_out_free) begin
                                    r_victim <= r_pos;
                                    r_state  <= S_SHIFT_CHK;
                                end
                            end else if (w_more) begin
                                r_pos   <= w_pos_inc;
                                r_state <= S_READ;
                            end else begin
                                r_state <= S_FINISH;
                            end
                        end
                        default: begin
                            if (w_ok) begin
                                if (w_more) begin
                                    r_pos   <= w_pos_inc;
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_FINISH;
                                end
                            end
                        end
                    endcase
                end
                S_HIT: begin
                    if (w_out_free) begin
                        r_state <= (r_kind == KIND_DROP) ? S_SHIFT_CHK : S_IDLE;
                    end
                end
                S_MISS: begin
                    if (w_ok) begin
                        if (r_kind == KIND_ACQUIRE) begin
                            if (w_full) begin
                                r_pos   <= r_victim;
                                r_state <= S_SHIFT_CHK;
                            end else begin
                                r_state <= S_APPEND;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_APPEND: begin
                    if (w_out_free) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_SHIFT_CHK: begin
                    // move later entries up one place, then shorten the list
                    if (w_more) begin
                        r_state <= S_SHIFT_WR;
                    end else begin
                        r_count <= r_count - CW'(1);
                        case (r_kind)
                            KIND_ACQUIRE: r_state <= S_APPEND;
                            KIND_SWEEP: begin
                                r_pos   <= r_victim;
                                r_state <= ((r_victim + CW'(1)) < r_count) ? S_READ
                                                                          : S_FINISH;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SHIFT_WR: begin
                    r_pos   <= w_pos_inc;
                    r_state <= S_SHIFT_CHK;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        if (r_kind == KIND_DROP_ALL) begin
                            r_count <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_event_res;
    assign o_entry_key  = r_entry_key;
    assign o_wrote_back = r_wrote_back;
    assign o_found      = r_found;
    assign o_last       = r_last;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lru/ttl cache directory. A scoreboard object
// keeps its own copy of the entry list and registers, predicts the events of
// every accepted request and checks each result transfer in order. Requests
// are a directed opening followed by random phases under several register
// settings, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module testbench;
    import lttl_pkg::*;

    localparam int DEPTH = 16;
    localparam int POOL  = 20;
    localparam int HOLD_CYCLES = 300;

    // kinds the block does not implement
    localparam logic [2:0] KIND_UNUSED_A = 3'd6;
    localparam logic [2:0] KIND_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] key;
        logic        wb;
        logic        found;
        logic        last;
    } t_dir_event;

    class t_dir_scoreboard;
        logic [31:0] tag     [DEPTH];
        logic [31:0] used_at [DEPTH];
        logic        dirty   [DEPTH];
        int          fill;
        logic [4:0]  cap_reg;
        logic [31:0] life_reg;
        t_dir_event  awaited [$];
        int          errors;

        function new();
            for (int i = 0; i < DEPTH; i++) begin
                tag[i]     = '0;
                used_at[i] = '0;
                dirty[i]   = 1'b0;
            end
            fill     = 0;
            cap_reg  = CAP_RESET;
            life_reg = LIFE_RESET;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
            if (idx == CFG_CAPACITY) begin
                cap_reg = data[4:0];
            end else if (idx == CFG_LIFE) begin
                life_reg = data;
            end
        endfunction

        function void post(logic [2:0] ev, logic [31:0] key, logic wb, logic found,
                           logic last);
            t_dir_event e;
            e.ev    = ev;
            e.key   = key;
            e.wb    = wb;
            e.found = found;
            e.last  = last;
            awaited = {awaited, e};
        endfunction

        // later entries move up one place
        function void close_gap(int idx);
            for (int i = idx; i + 1 < fill; i++) begin
                tag[i]     = tag[i+1];
                used_at[i] = used_at[i+1];
                dirty[i]   = dirty[i+1];
            end
            if (fill > 0) begin
                fill--;
                dirty[fill] = 1'b0;
            end
        endfunction

        function int find(logic [31:0] key);
            for (int i = 0; i < fill; i++) begin
                if (tag[i] == key) return i;
            end
            return -1;
        endfunction

        function void note_request(logic [2:0] kind, logic [31:0] key, logic [31:0] stamp);
            int          idx;
            int          victim;
            int          limit;
            int          i;
            logic [31:0] oldest;
            logic [31:0] age;
            case (kind)
                KIND_ACQUIRE: begin
                    idx = find(key);
                    if (idx >= 0) begin
                        used_at[idx] = stamp;
                        post(EV_HIT, key, 1'b0, 1'b1, 1'b1);
                    end else begin
                        limit = (cap_reg < 1) ? 1 : (cap_reg > DEPTH) ? DEPTH : cap_reg;
                        if (fill >= limit && fill > 0) begin
                            victim = 0;
                            oldest = stamp - used_at[0];
                            for (i = 1; i < fill; i++) begin
                                age = stamp - used_at[i];
                                if (age > oldest) begin
                                    oldest = age;
                                    victim = i;
                                end
                            end
                            post(EV_REMOVED, tag[victim], dirty[victim], 1'b0, 1'b0);
                            close_gap(victim);
                        end
                        if (fill < DEPTH) begin
                            tag[fill]     = key;
                            used_at[fill] = stamp;
                            dirty[fill]   = 1'b0;
                            fill++;
                        end
                        post(EV_LOADED, key, 1'b0, 1'b0, 1'b1);
                    end
                end
                KIND_SET_DIRTY: begin
                    idx = find(key);
                    if (idx >= 0) dirty[idx] = 1'b1;
                    post(EV_DONE, key, 1'b0, idx >= 0, 1'b1);
                end
                KIND_DROP: begin
                    idx = find(key);
                    if (idx >= 0) begin
                        post(EV_REMOVED, key, dirty[idx], 1'b1, 1'b1);
                        close_gap(idx);
                    end else begin
                        post(EV_DONE, key, 1'b0, 1'b0, 1'b1);
                    end
                end
                KIND_DROP_ALL: begin
                    for (i = 0; i < fill; i++) begin
                        post(EV_REMOVED, tag[i], dirty[i], 1'b0, 1'b0);
                        dirty[i] = 1'b0;
                    end
                    fill = 0;
                    post(EV_DONE, '0, 1'b0, 1'b0, 1'b1);
                end
                KIND_FLUSH: begin
                    for (i = 0; i < fill; i++) begin
                        if (dirty[i]) begin
                            post(EV_KEPT, tag[i], 1'b1, 1'b0, 1'b0);
                            dirty[i] = 1'b0;
                        end
                    end
                    post(EV_DONE, '0, 1'b0, 1'b0, 1'b1);
                end
                KIND_SWEEP: begin
                    i = 0;
                    while (i < fill) begin
                        age = stamp - used_at[i];
                        if (age > life_reg) begin
                            post(EV_REMOVED, tag[i], dirty[i], 1'b0, 1'b0);
                            close_gap(i);
                        end else begin
                            i++;
                        end
                    end
                    post(EV_DONE, '0, 1'b0, 1'b0, 1'b1);
                end
                default: begin
                    post(EV_DONE, '0, 1'b0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_dir_event got);
            t_dir_event want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: ev=%0d key=%h wb=%b found=%b last=%b",
                             got.ev, got.key, got.wb, got.found, got.last);
                return;
            end
            want = awaited.pop_front();
            if (got.ev !== want.ev || got.key !== want.key || got.wb !== want.wb ||
                got.found !== want.found || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected ev=%0d key=%h wb=%b found=%b last=%b",
                             want.ev, want.key, want.wb, want.found, want.last);
                    $display("          actual   ev=%0d key=%h wb=%b found=%b last=%b",
                             got.ev, got.key, got.wb, got.found, got.last);
                end
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [2:0]              i_kind = '0;
    logic [31:0]             i_key = '0;
    logic [31:0]             i_now_ms = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [2:0]              o_event_res;
    logic [31:0]             o_entry_key;
    logic                    o_wrote_back;
    logic                    o_found;
    logic                    o_last;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [31:0]             i_cfg_data = '0;

    t_dir_scoreboard sb = new();

    logic [31:0] key_pool [POOL];
    logic [31:0] clock_ms = '0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    lru_ttl_cache_directory_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_res  (o_event_res),
        .o_entry_key  (o_entry_key),
        .o_wrote_back (o_wrote_back),
        .o_found      (o_found),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watch every transfer on all three channels
    always @(posedge i_clk) begin
        t_dir_event got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) sb.note_request(i_kind, i_key, i_now_ms);
            if (o_out_valid && !i_out_stall) begin
                got.ev    = o_event_res;
                got.key   = o_entry_key;
                got.wb    = o_wrote_back;
                got.found = o_found;
                got.last  = o_last;
                sb.check_result(got);
            end
        end
    end

    // result side: random stalls, one long hold on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            i_out_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 33);
        end
    end

    task automatic send_req(logic [2:0] kind, logic [31:0] key, logic [31:0] stamp);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_now_ms   <= stamp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every event has come back and the block has gone quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int step_max);
        int          pick;
        logic [2:0]  kind;
        logic [31:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48)      kind = KIND_ACQUIRE;
            else if (pick < 63) kind = KIND_SET_DIRTY;
            else if (pick < 73) kind = KIND_DROP;
            else if (pick < 76) kind = KIND_DROP_ALL;
            else if (pick < 83) kind = KIND_FLUSH;
            else if (pick < 97) kind = KIND_SWEEP;
            else                kind = pick[0] ? KIND_UNUSED_A : KIND_UNUSED_B;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL - 1)]
                                               : $urandom;
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, step_max);
            send_req(kind, key, clock_ms);
        end
    endtask

    initial begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, hits, tie on age, flush, wrapped idle time
        write_reg(CFG_CAPACITY, 32'd3);
        write_reg(CFG_LIFE, 32'd100);
        send_req(KIND_SWEEP, 32'h0, 32'h0);
        send_req(KIND_DROP_ALL, 32'h0, 32'h0);
        send_req(KIND_FLUSH, 32'h0, 32'h0);
        send_req(KIND_SET_DIRTY, 32'hFFFF_FFFF, 32'h0);
        send_req(KIND_DROP, 32'h0, 32'h0);
        send_req(KIND_ACQUIRE, 32'h0, 32'd0);
        send_req(KIND_ACQUIRE, 32'hFFFF_FFFF, 32'd10);
        send_req(KIND_ACQUIRE, 32'h5A5A_5A5A, 32'd10);
        send_req(KIND_ACQUIRE, 32'h0, 32'd20);
        send_req(KIND_SET_DIRTY, 32'hFFFF_FFFF, 32'd20);
        send_req(KIND_ACQUIRE, 32'h1234_5678, 32'd20);
        send_req(KIND_SET_DIRTY, 32'h5A5A_5A5A, 32'd20);
        send_req(KIND_FLUSH, 32'h0, 32'd20);
        send_req(KIND_SET_DIRTY, 32'h0, 32'd20);
        send_req(KIND_DROP, 32'h0, 32'd20);
        send_req(KIND_SWEEP, 32'h0, 32'd200);
        send_req(KIND_ACQUIRE, 32'hA5A5_A5A5, 32'hFFFF_FFF0);
        send_req(KIND_SWEEP, 32'h0, 32'h0000_0010);
        send_req(KIND_ACQUIRE, 32'h0000_0001, 32'h0000_0050);
        send_req(KIND_SET_DIRTY, 32'hA5A5_A5A5, 32'h0000_0050);
        send_req(KIND_DROP_ALL, 32'h0, 32'h0000_0060);
        send_req(KIND_UNUSED_A, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_req(KIND_UNUSED_B, 32'h0, 32'h0);
        settle();

        // a zero capacity behaves as one
        write_reg(CFG_CAPACITY, 32'd0);
        send_req(KIND_ACQUIRE, 32'd7, 32'd1);
        send_req(KIND_ACQUIRE, 32'd8, 32'd2);
        settle();

        clock_ms = 32'd1000;
        write_reg(CFG_CAPACITY, 32'd16);
        write_reg(CFG_LIFE, 32'd60000);
        calm = 1'b1;
        run_phase(50, 400);
        calm = 1'b0;
        run_phase(20, 3000);
        settle();

        // capacity drops below the number of entries held
        write_reg(CFG_CAPACITY, 32'd2);
        write_reg(CFG_LIFE, 32'd0);
        run_phase(40, 50);
        settle();

        write_reg(CFG_CAPACITY, 32'd31);
        write_reg(CFG_LIFE, 32'hFFFF_FFFF);
        hold_req = 1'b1;
        run_phase(45, 100000);
        settle();

        write_reg(CFG_CAPACITY, 32'd5);
        write_reg(CFG_LIFE, 32'd3000);
        run_phase(45, 1500);
        settle();

        if (sb.errors == 0) begin
            $display("[lru_ttl_cache_directory_top] OK");
        end else begin
            $display("[lru_ttl_cache_directory_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("[lru_ttl_cache_directory_top] ERROR");
        $finish;
    end

endmodule
